@@ rtl/core/qnl_pkg.sv @@
// Shared stage numbering and lane count for the quaternion nlerp pipeline.
package qnl_pkg;

    // One lane per quaternion component
    localparam int LANES = 4;

    // Pipeline stage indices up to the first root search step
    localparam int ST_MUL = 0;
    localparam int ST_DOT = 1;
    localparam int ST_RND = 2;
    localparam int ST_SQ  = 3;
    localparam int ST_SUM = 4;
    localparam int ST_IT0 = 5;

    // Stages beyond the FRAC_BITS+1 search steps (five ahead, one output)
    localparam int EXTRA_STAGES = 6;

endpackage

@@ rtl/core/qnl_front.sv @@
// One component lane: blend products, shorter-arc blend, rounding and squaring.
module qnl_front #(
    parameter int COMP_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                              clk,
    input  logic [FRAC_BITS+qnl_pkg::EXTRA_STAGES:0] en,
    input  logic signed [COMP_WIDTH-1:0]      a,
    input  logic signed [COMP_WIDTH-1:0]      b,
    input  logic [FRAC_BITS:0]                blend,
    input  logic                              dot_neg,
    output logic signed [2*COMP_WIDTH-1:0]    ab,
    output logic [2*COMP_WIDTH+3:0]           sq,
    output logic                              neg
);
    import qnl_pkg::*;

    localparam int VW  = COMP_WIDTH + FRAC_BITS + 3;
    localparam int MW  = COMP_WIDTH + 2;
    localparam int SQW = 2 * MW;
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;
    localparam logic [VW-1:0] HALF = VW'(1) << (FRAC_BITS - 1);

    logic [FRAC_BITS:0]          f_cl;
    logic [FRAC_BITS:0]          s1;
    logic signed [VW-1:0]        sa_c;
    logic signed [VW-1:0]        fb_c;
    logic signed [2*COMP_WIDTH-1:0] ab_c;
    logic signed [2*COMP_WIDTH-1:0] ab_reg;
    logic signed [VW-1:0]        sa0_reg, fb0_reg, sa1_reg, fb1_reg;
    logic signed [VW-1:0]        v_c;
    logic [VW-1:0]               mag_c, rnd_c;
    logic signed [MW-1:0]        m_next, m_reg;
    logic signed [SQW-1:0]       sq_c;
    logic [SQW-1:0]              sq_reg;
    logic                        neg_reg;

    // Clamp blend to one, weights and products
    always_comb
    begin
        f_cl = (blend > ONE) ? ONE : blend;
        s1   = ONE - f_cl;
        sa_c = $signed({1'b0, s1}) * a;
        fb_c = $signed({1'b0, f_cl}) * b;
        ab_c = a * b;
    end

    // Shorter-arc blend, round half away from zero
    always_comb
    begin
        v_c    = dot_neg ? (sa1_reg - fb1_reg) : (sa1_reg + fb1_reg);
        mag_c  = v_c[VW-1] ? VW'(-v_c) : VW'(v_c);
        rnd_c  = (mag_c + HALF) >> FRAC_BITS;
        m_next = v_c[VW-1] ? -$signed(MW'(rnd_c)) : $signed(MW'(rnd_c));
        sq_c   = m_reg * m_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_MUL])
        begin
            ab_reg  <= ab_c;
            sa0_reg <= sa_c;
            fb0_reg <= fb_c;
        end
        if (en[ST_DOT])
        begin
            sa1_reg <= sa0_reg;
            fb1_reg <= fb0_reg;
        end
        if (en[ST_RND])
        begin
            m_reg <= m_next;
        end
        if (en[ST_SQ])
        begin
            sq_reg  <= SQW'(sq_c);
            neg_reg <= m_reg[MW-1];
        end
    end

    assign ab  = ab_reg;
    assign sq  = sq_reg;
    assign neg = neg_reg;

endmodule

@@ rtl/core/qnl_root.sv @@
// One component lane: bit-serial search for round(|m| * 2^F / sqrt(S)), one bit a stage.
module qnl_root #(
    parameter int COMP_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                                     clk,
    input  logic [FRAC_BITS+qnl_pkg::EXTRA_STAGES:0] en,
    input  logic [2*COMP_WIDTH+3:0]                  sq,
    input  logic                                     neg,
    input  logic [2*COMP_WIDTH+5:0]                  s,
    output logic [FRAC_BITS:0]                       r_out,
    output logic                                     neg_out,
    output logic [2*COMP_WIDTH+5:0]                  s_out
);
    import qnl_pkg::*;

    localparam int SW = 2 * COMP_WIDTH + 6;
    localparam int PW = SW + 2 * FRAC_BITS + 6;

    logic signed [PW-1:0] rhs0_reg;
    logic                 neg0_reg;

    logic [FRAC_BITS:0]   r_reg   [0:FRAC_BITS];
    logic signed [PW-1:0] p_reg   [0:FRAC_BITS];
    logic signed [PW-1:0] q_reg   [0:FRAC_BITS];
    logic signed [PW-1:0] rhs_reg [0:FRAC_BITS];
    logic [SW-1:0]        s_reg   [0:FRAC_BITS];
    logic                 neg_reg [0:FRAC_BITS];

    // Target: |m|^2 scaled by 2^(2F+2)
    always_ff @(posedge clk)
    begin
        if (en[ST_SUM])
        begin
            rhs0_reg <= $signed(PW'(sq)) <<< (2 * FRAC_BITS + 2);
            neg0_reg <= neg;
        end
    end

    // Each step keeps P = (2r-1)^2*S and Q = (2r-1)*S so trials need only shifts and adds
    for (genvar j = 0; j <= FRAC_BITS; j++)
    begin : g_step
        localparam int BIT = FRAC_BITS - j;
        logic [FRAC_BITS:0]   r_i;
        logic signed [PW-1:0] p_i, q_i, rhs_i, sx, cand;
        logic [SW-1:0]        s_i;
        logic                 neg_i, ok;

        if (j == 0)
        begin : g_first
            assign r_i   = '0;
            assign s_i   = s;
            assign p_i   = $signed(PW'(s));
            assign q_i   = -$signed(PW'(s));
            assign rhs_i = rhs0_reg;
            assign neg_i = neg0_reg;
        end
        else
        begin : g_next
            assign r_i   = r_reg[j-1];
            assign s_i   = s_reg[j-1];
            assign p_i   = p_reg[j-1];
            assign q_i   = q_reg[j-1];
            assign rhs_i = rhs_reg[j-1];
            assign neg_i = neg_reg[j-1];
        end

        assign sx   = $signed(PW'(s_i));
        assign cand = p_i + (q_i <<< (BIT + 2)) + (sx <<< (2 * BIT + 2));
        assign ok   = ((j == 0) || !r_i[FRAC_BITS]) && (cand <= rhs_i);

        always_ff @(posedge clk)
        begin
            if (en[ST_IT0 + j])
            begin
                r_reg[j]   <= ok ? (r_i | ((FRAC_BITS+1)'(1) << BIT)) : r_i;
                p_reg[j]   <= ok ? cand : p_i;
                q_reg[j]   <= ok ? (q_i + (sx <<< (BIT + 1))) : q_i;
                s_reg[j]   <= s_i;
                rhs_reg[j] <= rhs_i;
                neg_reg[j] <= neg_i;
            end
        end
    end

    assign r_out   = r_reg[FRAC_BITS];
    assign neg_out = neg_reg[FRAC_BITS];
    assign s_out   = s_reg[FRAC_BITS];

endmodule

@@ rtl/core/quaternion_nlerp_normalize.sv @@
// Top level: four component lanes, dot/norm merge, output saturation and flow control.
// Stages: multiply, dot sign, round, square, norm sum, root search steps, output register.
// Throughput: one beat per cycle unless the output stalls; each lane runs its FRAC_BITS+1
// root search steps as separate pipeline stages; stalled stages fill bubbles below them.
// Reset: rst_n asynchronous, active low, clears every stage valid; data regs are not reset.
module quaternion_nlerp_normalize #(
    parameter int COMP_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend, zero pad
    input  logic [((8*COMP_WIDTH+FRAC_BITS+1+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // r_x, r_y, r_z, r_w
    output logic [4*COMP_WIDTH-1:0] m_axis_tdata,
    // degenerate
    output logic m_axis_tuser
);
    import qnl_pkg::*;

    localparam int NST = FRAC_BITS + EXTRA_STAGES + 1;
    localparam int SW  = 2 * COMP_WIDTH + 6;
    localparam int DW  = 2 * COMP_WIDTH + 2;
    localparam int EW  = COMP_WIDTH + FRAC_BITS + 2;
    localparam logic signed [EW-1:0] CMAX = EW'((64'(1) << (COMP_WIDTH - 1)) - 1);
    localparam logic signed [EW-1:0] CMIN = -$signed(EW'(64'(1) << (COMP_WIDTH - 1)));

    logic [NST-1:0] valid_reg, valid_next;
    logic [NST:0]   ready;

    logic signed [COMP_WIDTH-1:0]   a_in [LANES];
    logic signed [COMP_WIDTH-1:0]   b_in [LANES];
    logic [FRAC_BITS:0]             blend_in;
    logic signed [2*COMP_WIDTH-1:0] ab   [LANES];
    logic [2*COMP_WIDTH+3:0]        sq   [LANES];
    logic                           m_neg[LANES];
    logic [FRAC_BITS:0]             r_fin[LANES];
    logic                           n_fin[LANES];
    logic [SW-1:0]                  s_fin[LANES];

    logic signed [DW-1:0]           dot_c;
    logic                           dot_neg_reg;
    logic [SW-1:0]                  s_c, s_reg;
    logic [4*COMP_WIDTH-1:0]        data_next, data_reg;
    logic                           degen_next, degen_reg;

    // Ready ripples back through empty or draining stages
    assign ready[NST] = m_axis_tready;
    for (genvar k = 0; k < NST; k++)
    begin : g_rdy
        assign ready[k] = !valid_reg[k] || ready[k+1];
    end

    always_comb
    begin
        valid_next[0] = ready[0] ? s_axis_tvalid : valid_reg[0];
        for (int k = 1; k < NST; k++)
        begin
            if (ready[k])
                valid_next[k] = valid_reg[k-1];
            else
                valid_next[k] = valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // Unpack input beat
    assign blend_in = s_axis_tdata[8*COMP_WIDTH +: FRAC_BITS+1];

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        assign a_in[i] = s_axis_tdata[i*COMP_WIDTH +: COMP_WIDTH];
        assign b_in[i] = s_axis_tdata[(4+i)*COMP_WIDTH +: COMP_WIDTH];

        qnl_front #(
            .COMP_WIDTH (COMP_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_front (
            .clk     (clk),
            .en      (ready[NST-1:0]),
            .a       (a_in[i]),
            .b       (b_in[i]),
            .blend   (blend_in),
            .dot_neg (dot_neg_reg),
            .ab      (ab[i]),
            .sq      (sq[i]),
            .neg     (m_neg[i])
        );

        qnl_root #(
            .COMP_WIDTH (COMP_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_root (
            .clk     (clk),
            .en      (ready[NST-1:0]),
            .sq      (sq[i]),
            .neg     (m_neg[i]),
            .s       (s_reg),
            .r_out   (r_fin[i]),
            .neg_out (n_fin[i]),
            .s_out   (s_fin[i])
        );
    end

    // Merge: dot sign and squared norm
    always_comb
    begin
        dot_c = '0;
        s_c   = '0;
        for (int i = 0; i < LANES; i++)
        begin
            dot_c = dot_c + DW'(ab[i]);
            s_c   = s_c + SW'(sq[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[ST_DOT])
            dot_neg_reg <= dot_c[DW-1];
        if (ready[ST_SUM])
            s_reg <= s_c;
    end

    // Output: sign, saturate, zero on degenerate norm
    always_comb
    begin
        logic signed [EW-1:0] v;
        degen_next = (s_fin[0] == '0);
        data_next  = '0;
        for (int i = 0; i < LANES; i++)
        begin
            v = n_fin[i] ? -$signed(EW'(r_fin[i])) : $signed(EW'(r_fin[i]));
            if (v > CMAX)
                v = CMAX;
            else if (v < CMIN)
                v = CMIN;
            if (!degen_next)
                data_next[i*COMP_WIDTH +: COMP_WIDTH] = v[COMP_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[NST-1])
        begin
            data_reg  <= data_next;
            degen_reg <= degen_next;
        end
    end

    assign s_axis_tready = ready[0];
    assign m_axis_tvalid = valid_reg[NST-1];
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = degen_reg;

    // A degenerate beat carries all-zero components
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("degenerate beat with nonzero data");

    // With the output stage empty the pipeline must take a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    // An accepted beat reaches the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> valid_reg[0])
        else $error("accepted beat lost at entry");

endmodule
